>>> sv/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/tmmp_pkg.sv
`default_nettype none

package tmmp_pkg;

   // Parser phase codes.
   localparam logic [3:0] PH_HDR  = 4'd0;
   localparam logic [3:0] PH_TXT0 = 4'd1;
   localparam logic [3:0] PH_TXT1 = 4'd2;
   localparam logic [3:0] PH_TXT2 = 4'd3;
   localparam logic [3:0] PH_TXT3 = 4'd4;
   localparam logic [3:0] PH_MAP  = 4'd5;
   localparam logic [3:0] PH_KEY  = 4'd6;
   localparam logic [3:0] PH_TYPE = 4'd7;
   localparam logic [3:0] PH_HI   = 4'd8;
   localparam logic [3:0] PH_LO   = 4'd9;
   localparam logic [3:0] PH_I8   = 4'd10;
   localparam logic [3:0] PH_DONE = 4'd11;

   // Message framing constants.
   localparam logic [7:0] HDR_MARKER    = 8'hA4;
   localparam logic [7:0] MAP_TAG_MASK  = 8'hF0;
   localparam logic [7:0] MAP_TAG       = 8'h80;
   localparam logic [7:0] TYPE_INT16    = 8'hD1;
   localparam logic [7:0] TYPE_INT8     = 8'hD0;

   // Status codes reported with a finished message.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_TRUNCATED = 3'd1;
   localparam logic [2:0] ERR_MARKER    = 3'd2;
   localparam logic [2:0] ERR_TEXT      = 3'd3;
   localparam logic [2:0] ERR_MAP       = 3'd4;
   localparam logic [2:0] ERR_FULL      = 3'd5;

   // Register map.
   localparam int CSR_ADDR_W = 3;
   localparam logic [3:0] PAIR_LIMIT_RESET = 4'd10;

   // One accepted byte held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } tmmp_byte_type;

   // Expected text byte for each of the four text phases.
   function automatic logic [7:0] hdr_char(input logic [1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         2'd0: ch = 8'h51;
         2'd1: ch = 8'h4D;
         2'd2: ch = 8'h56;
         2'd3: ch = 8'h31;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

>>> sv/tmmp_req_if.sv
`default_nettype none

interface tmmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> sv/tmmp_rsp_if.sv
`default_nettype none

interface tmmp_rsp_if;
   logic               valid;
   logic               ready;
   logic               pair_valid;
   logic [7:0]         pair_key;
   logic signed [15:0] pair_value;
   logic               done_res;
   logic               status_ok;
   logic [2:0]         error_code;

   modport source (output valid, output pair_valid, output pair_key, output pair_value,
                   output done_res, output status_ok, output error_code, input ready);
   modport sink   (input valid, input pair_valid, input pair_key, input pair_value,
                   input done_res, input status_ok, input error_code, output ready);
endinterface

`default_nettype wire

>>> sv/tmmp_csr.sv
`default_nettype none

module tmmp_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [tmmp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready,
   output logic [3:0]                           pair_limit
);
   import tmmp_pkg::*;

   logic [3:0] limit_ff;
   logic [3:0] limit_in;
   logic       hit;

   // Only the first word holds a register.
   assign hit        = (csr_paddr[CSR_ADDR_W-1] == 1'b0);
   assign csr_pready = 1'b1;

   // Write on the access phase of a transfer.
   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         limit_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= PAIR_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Read data.
   assign csr_prdata = hit ? {28'd0, limit_ff} : 32'd0;
   assign pair_limit = limit_ff;

endmodule

`default_nettype wire

>>> sv/tmmp_in_stage.sv
`default_nettype none

module tmmp_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   tmmp_req_if.sink                req,
   input  wire logic               advance,
   output tmmp_pkg::tmmp_byte_type held
);
   import tmmp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       take;

   // The register frees up in the same cycle its byte moves on.
   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded on each transfer.
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req.data_byte;
         last_ff <= req.last_byte;
      end
   end

   assign held.valid = valid_ff;
   assign held.data  = data_ff;
   assign held.last  = last_ff;

endmodule

`default_nettype wire

>>> sv/tmmp_parser.sv
`default_nettype none

module tmmp_parser (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tmmp_pkg::tmmp_byte_type held,
   input  wire logic [3:0]              pair_limit,
   tmmp_rsp_if.source                   rsp,
   output logic                         advance
);
   import tmmp_pkg::*;

   // Message state.
   logic [3:0] phase_ff, phase_in;
   logic [3:0] expected_ff, expected_in;
   logic [3:0] seen_ff, seen_in;
   logic [7:0] key_ff, key_in;
   logic [7:0] high_ff, high_in;

   // Result register.
   logic        out_vld_ff, out_vld_in;
   logic        pair_ff;
   logic [7:0]  okey_ff;
   logic [15:0] oval_ff;
   logic        done_ff;
   logic        ok_ff;
   logic [2:0]  err_ff;

   // Result of the current byte.
   logic        r_pair;
   logic [7:0]  r_key;
   logic [15:0] r_val;
   logic        r_done;
   logic        r_ok;
   logic [2:0]  r_err;
   logic        has_result;

   logic [7:0]  b;
   logic        cp;
   logic [15:0] cp_val;
   logic [3:0]  seen_inc;

   assign b        = held.data;
   assign seen_inc = seen_ff + 4'd1;

   // The byte moves on whenever the result register is free or being drained.
   assign advance = held.valid && (!out_vld_ff || rsp.ready);

   // Next message state and result for the held byte.
   always_comb begin
      phase_in    = phase_ff;
      expected_in = expected_ff;
      seen_in     = seen_ff;
      key_in      = key_ff;
      high_in     = high_ff;
      r_pair      = 1'b0;
      r_key       = 8'd0;
      r_val       = 16'd0;
      r_done      = 1'b0;
      r_ok        = 1'b0;
      r_err       = ERR_NONE;
      cp          = 1'b0;
      cp_val      = 16'd0;

      unique case (phase_ff)
         PH_HDR: begin
            if (b == HDR_MARKER) begin
               phase_in = PH_TXT0;
            end else begin
               r_done   = 1'b1;
               r_err    = ERR_MARKER;
               phase_in = PH_DONE;
            end
         end
         PH_TXT0, PH_TXT1, PH_TXT2, PH_TXT3: begin
            if (b == hdr_char(2'(phase_ff - PH_TXT0))) begin
               phase_in = phase_ff + 4'd1;
            end else begin
               r_done   = 1'b1;
               r_err    = ERR_TEXT;
               phase_in = PH_DONE;
            end
         end
         PH_MAP: begin
            if ((b & MAP_TAG_MASK) == MAP_TAG) begin
               expected_in = b[3:0];
               seen_in     = 4'd0;
               if (b[3:0] == 4'd0) begin
                  r_done   = 1'b1;
                  r_ok     = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_KEY;
               end
            end else begin
               r_done   = 1'b1;
               r_err    = ERR_MAP;
               phase_in = PH_DONE;
            end
         end
         PH_KEY: begin
            key_in   = b;
            phase_in = PH_TYPE;
         end
         PH_TYPE: begin
            if (b == TYPE_INT16) begin
               phase_in = PH_HI;
            end else if (b == TYPE_INT8) begin
               phase_in = PH_I8;
            end else begin
               cp     = 1'b1;
               cp_val = {{8{b[7]}}, b};
            end
         end
         PH_HI: begin
            high_in  = b;
            phase_in = PH_LO;
         end
         PH_LO: begin
            cp     = 1'b1;
            cp_val = {high_ff, b};
         end
         PH_I8: begin
            cp     = 1'b1;
            cp_val = {{8{b[7]}}, b};
         end
         default: begin
            // Finished or unused phase: the byte is dropped.
         end
      endcase

      // A completed pair is either reported or, with the table full, ends the message.
      if (cp) begin
         if (seen_ff >= pair_limit) begin
            r_done   = 1'b1;
            r_err    = ERR_FULL;
            phase_in = PH_DONE;
         end else begin
            r_pair  = 1'b1;
            r_key   = key_ff;
            r_val   = cp_val;
            seen_in = seen_inc;
            if (seen_inc == expected_ff) begin
               r_done   = 1'b1;
               r_ok     = 1'b1;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_KEY;
            end
         end
      end

      // The last byte reports an unfinished message and rearms the parser.
      if (held.last) begin
         if (!r_done && phase_in != PH_DONE && phase_in <= PH_I8) begin
            r_done = 1'b1;
            r_ok   = 1'b0;
            r_err  = ERR_TRUNCATED;
         end
         phase_in    = PH_HDR;
         expected_in = 4'd0;
         seen_in     = 4'd0;
         key_in      = 8'd0;
         high_in     = 8'd0;
      end
   end

   assign has_result = r_pair || r_done;

   // Message state advances with each byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR;
         expected_ff <= 4'd0;
         seen_ff     <= 4'd0;
         key_ff      <= 8'd0;
         high_ff     <= 8'd0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         expected_ff <= expected_in;
         seen_ff     <= seen_in;
         key_ff      <= key_in;
         high_ff     <= high_in;
      end
   end

   // Result register valid flag.
   always_comb begin
      if (advance) begin
         out_vld_in = has_result;
      end else begin
         out_vld_in = out_vld_ff && !rsp.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   // Result payload is loaded only when a new result is produced.
   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         pair_ff <= r_pair;
         okey_ff <= r_key;
         oval_ff <= r_val;
         done_ff <= r_done;
         ok_ff   <= r_ok;
         err_ff  <= r_err;
      end
   end

   assign rsp.valid      = out_vld_ff;
   assign rsp.pair_valid = pair_ff;
   assign rsp.pair_key   = okey_ff;
   assign rsp.pair_value = $signed(oval_ff);
   assign rsp.done_res   = done_ff;
   assign rsp.status_ok  = ok_ff;
   assign rsp.error_code = err_ff;

endmodule

`default_nettype wire

>>> sv/tagged_map_message_parser.sv
// Byte-serial parser for a small tagged map message. Bytes arrive on the req_chan
// channel, one transfer per cycle at full rate; each byte sits in an input register,
// is decoded combinationally against the message state, and any result it causes
// (a decoded pair, a finish status, or both) is loaded into the output register as
// its byte leaves the input register, and from there it transfers on rsp_chan.
// The per-byte state update is the one loop that sets the rate of one byte per cycle;
// a stalled result register holds both stages. The pair limit register sits at byte
// address 0 of the csr port and resets to 10.
`default_nettype none

module tagged_map_message_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tmmp_req_if.sink                             req_chan,
   tmmp_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [tmmp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import tmmp_pkg::*;

   tmmp_byte_type held;
   logic          advance;
   logic [3:0]    pair_limit;

   // Configuration register.
   tmmp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pair_limit  (pair_limit)
   );

   // Input register.
   tmmp_in_stage u_in (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .advance (advance),
      .held    (held)
   );

   // Decode, message state and result register.
   tmmp_parser u_parse (
      .clock      (clock),
      .reset      (reset),
      .held       (held),
      .pair_limit (pair_limit),
      .rsp        (rsp_chan),
      .advance    (advance)
   );

endmodule

`default_nettype wire

>>> sv/tmmp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tmmp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_pair_valid,
   input wire logic [7:0]  rsp_pair_key,
   input wire logic [15:0] rsp_pair_value,
   input wire logic        rsp_done_res,
   input wire logic        rsp_status_ok,
   input wire logic [2:0]  rsp_error_code
);
   import tmmp_pkg::*;

   logic [29:0] payload;
   logic        pair_blank;
   logic        clean_ok;
   logic        done_fail;
   logic        code_known;

   // Result fields gathered for the checks below.
   assign payload    = {rsp_pair_valid, rsp_pair_key, rsp_pair_value, rsp_done_res,
                        rsp_status_ok, rsp_error_code};
   assign pair_blank = (rsp_pair_key == 8'd0) && (rsp_pair_value == 16'd0);
   assign clean_ok   = rsp_done_res && (rsp_error_code == ERR_NONE);
   assign done_fail  = rsp_done_res && !rsp_status_ok;
   assign code_known = (rsp_error_code != ERR_NONE) && (rsp_error_code <= ERR_FULL);

   // A stalled result keeps its valid and its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(payload))

   // Every result carries a pair, a finish, or both.
   `ASSERT_IMPLIES(a_rsp_nonempty, clock, reset, rsp_valid, rsp_pair_valid || rsp_done_res)

   // Without a pair the key and value fields are zero.
   `ASSERT_IMPLIES(a_no_pair_zero, clock, reset, rsp_valid && !rsp_pair_valid, pair_blank)

   // A success status only comes with a finish and no error code.
   `ASSERT_IMPLIES(a_ok_clean, clock, reset, rsp_valid && rsp_status_ok, clean_ok)

   // A failed finish carries a defined error code.
   `ASSERT_IMPLIES(a_fail_code, clock, reset, rsp_valid && done_fail, code_known)

endmodule

bind tagged_map_message_parser tmmp_checker u_tmmp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_pair_valid (rsp_chan.pair_valid),
   .rsp_pair_key   (rsp_chan.pair_key),
   .rsp_pair_value (rsp_chan.pair_value),
   .rsp_done_res   (rsp_chan.done_res),
   .rsp_status_ok  (rsp_chan.status_ok),
   .rsp_error_code (rsp_chan.error_code)
);

`default_nettype wire

>>> tb/tagged_map_message_parser_tb.sv
module tagged_map_message_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tmmp_pkg::*;

   // One result as it appears on the response channel.
   typedef struct packed {
      logic               pair_valid;
      logic [7:0]         key;
      logic signed [15:0] value;
      logic               done;
      logic               ok;
      logic [2:0]         err;
   } parse_result_type;

   typedef logic [7:0] byte_q_type [$];

   localparam logic [31:0]           MAGIC_TEXT      = "QMV1";
   localparam logic [CSR_ADDR_W-1:0] PAIR_LIMIT_ADDR = '0;
   localparam int                    DRAIN_CYCLES    = 8;
   localparam int                    CYCLE_LIMIT     = 400000;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   tmmp_req_if req_bus ();
   tmmp_rsp_if rsp_bus ();

   tagged_map_message_parser uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Parser state mirrored by the testbench.
   logic [3:0] phase_now  = PH_HDR;
   logic [3:0] pairs_due  = '0;
   logic [3:0] pairs_done = '0;
   logic [7:0] key_held   = '0;
   logic [7:0] high_held  = '0;
   logic [3:0] limit_now  = PAIR_LIMIT_RESET;

   parse_result_type awaited_reports [$];

   int error_count    = 0;
   int cycle_count    = 0;
   int bytes_accepted = 0;
   int reports_seen   = 0;
   int pairs_seen_out = 0;
   int burst_left     = 0;
   int finish_codes [0:7];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Message state returns to the start of a new message.
   function automatic void clear_message();
      phase_now  = PH_HDR;
      pairs_due  = '0;
      pairs_done = '0;
      key_held   = '0;
      high_held  = '0;
   endfunction

   function automatic void end_with_error(input logic [2:0] code, inout parse_result_type r);
      r.done    = 1'b1;
      r.ok      = 1'b0;
      r.err     = code;
      phase_now = PH_DONE;
   endfunction

   // A finished value either becomes a reported pair or overflows the table.
   function automatic void close_pair(input logic [15:0] v, inout parse_result_type r);
      if (pairs_done >= limit_now) begin
         end_with_error(ERR_FULL, r);
      end else begin
         r.pair_valid = 1'b1;
         r.key        = key_held;
         r.value      = v;
         pairs_done   = pairs_done + 4'd1;
         if (pairs_done == pairs_due) begin
            r.done    = 1'b1;
            r.ok      = 1'b1;
            r.err     = ERR_NONE;
            phase_now = PH_DONE;
         end else begin
            phase_now = PH_KEY;
         end
      end
   endfunction

   // Advances the mirrored parser by one byte; returns 1 when a result is due.
   function automatic bit decode_byte(input logic [7:0] b, input logic is_last,
                                      output parse_result_type r);
      r = '0;
      case (phase_now)
         PH_HDR: begin
            if (b == HDR_MARKER) phase_now = PH_TXT0;
            else end_with_error(ERR_MARKER, r);
         end
         PH_TXT0, PH_TXT1, PH_TXT2, PH_TXT3: begin
            if (b == MAGIC_TEXT[31 - 8 * (phase_now - PH_TXT0) -: 8])
               phase_now = phase_now + 4'd1;
            else
               end_with_error(ERR_TEXT, r);
         end
         PH_MAP: begin
            if ((b & MAP_TAG_MASK) == MAP_TAG) begin
               pairs_due  = b[3:0];
               pairs_done = '0;
               if (pairs_due == 4'd0) begin
                  r.done    = 1'b1;
                  r.ok      = 1'b1;
                  r.err     = ERR_NONE;
                  phase_now = PH_DONE;
               end else begin
                  phase_now = PH_KEY;
               end
            end else begin
               end_with_error(ERR_MAP, r);
            end
         end
         PH_KEY: begin
            key_held  = b;
            phase_now = PH_TYPE;
         end
         PH_TYPE: begin
            if (b == TYPE_INT16) phase_now = PH_HI;
            else if (b == TYPE_INT8) phase_now = PH_I8;
            else close_pair({{8{b[7]}}, b}, r);
         end
         PH_HI: begin
            high_held = b;
            phase_now = PH_LO;
         end
         PH_LO: close_pair({high_held, b}, r);
         PH_I8: close_pair({{8{b[7]}}, b}, r);
         default: ;
      endcase
      // A last byte that leaves the message open reports truncation, then rearms.
      if (is_last) begin
         if (!r.done && phase_now != PH_DONE && phase_now <= PH_I8) begin
            r.done = 1'b1;
            r.ok   = 1'b0;
            r.err  = ERR_TRUNCATED;
         end
         clear_message();
      end
      return r.pair_valid || r.done;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   // Predicts on every byte transfer and checks every result transfer.
   always @(posedge clock) begin
      parse_result_type want;
      parse_result_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
      if (reset) begin
         limit_now = PAIR_LIMIT_RESET;
         clear_message();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            bytes_accepted++;
            if (decode_byte(req_bus.data_byte, req_bus.last_byte, want))
               awaited_reports.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.pair_valid = rsp_bus.pair_valid;
            got.key        = rsp_bus.pair_key;
            got.value      = rsp_bus.pair_value;
            got.done       = rsp_bus.done_res;
            got.ok         = rsp_bus.status_ok;
            got.err        = rsp_bus.error_code;
            reports_seen++;
            if (got.pair_valid) pairs_seen_out++;
            if (got.done) finish_codes[got.err]++;
            if (awaited_reports.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none actual %h", $time, got);
            end else begin
               want = awaited_reports.pop_front();
               check_field("pair_valid", 16'(want.pair_valid), 16'(got.pair_valid));
               check_field("pair_key", 16'(want.key), 16'(got.key));
               check_field("pair_value", want.value, got.value);
               check_field("done_res", 16'(want.done), 16'(got.done));
               check_field("status_ok", 16'(want.ok), 16'(got.ok));
               check_field("error_code", 16'(want.err), 16'(got.err));
            end
         end
      end
   end

   // The receiver cycles through stretches of full rate, light, heavy and periodic stalls.
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      rsp_bus.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 160);
         for (int i = 0; i < span; i++) begin
            @(negedge clock);
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ((i % 5) != 4);
            endcase
         end
      end
   end

   // One byte transfer; the sender runs in bursts separated by random gaps.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= is_last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_message(input byte_q_type m);
      foreach (m[i]) send_byte(m[i], i == m.size() - 1);
   endtask

   // Waits until the block has nothing left to report and has settled.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_pair_limit_readback();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= PAIR_LIMIT_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[3:0] !== limit_now) begin
         error_count++;
         $display("%0t: pair_limit readback, expected %h actual %h",
                  $time, limit_now, csr_prdata[3:0]);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_pair_limit(input logic [3:0] value);
      wait_idle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PAIR_LIMIT_ADDR;
      csr_pwdata  <= {28'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      limit_now = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      check_pair_limit_readback();
   endtask

   function automatic byte_q_type header_bytes();
      byte_q_type m;
      m.push_back(HDR_MARKER);
      for (int i = 0; i < 4; i++) m.push_back(MAGIC_TEXT[31 - 8 * i -: 8]);
      return m;
   endfunction

   // Well-formed message with random keys and a mix of value encodings.
   function automatic byte_q_type make_map(input int count);
      byte_q_type  m;
      logic [15:0] v;
      logic [7:0]  b;
      m = header_bytes();
      m.push_back(MAP_TAG | 8'(count));
      repeat (count) begin
         m.push_back(8'($urandom));
         case ($urandom_range(0, 2))
            0: begin
               case ($urandom_range(0, 5))
                  0: v = 16'h7FFF;
                  1: v = 16'h8000;
                  2: v = 16'h0000;
                  3: v = 16'hFFFF;
                  default: v = 16'($urandom);
               endcase
               m.push_back(TYPE_INT16);
               m.push_back(v[15:8]);
               m.push_back(v[7:0]);
            end
            1: begin
               m.push_back(TYPE_INT8);
               m.push_back(8'($urandom));
            end
            default: begin
               do b = 8'($urandom); while (b == TYPE_INT16 || b == TYPE_INT8);
               m.push_back(b);
            end
         endcase
      end
      return m;
   endfunction

   task automatic test_reset_value();
      check_pair_limit_readback();
   endtask

   // Every value encoding, the int16 minimum, and the last pair finishing the map.
   task automatic test_well_formed_map();
      byte_q_type m;
      m = header_bytes();
      m = {m, 8'h83, 8'h00, TYPE_INT16, 8'h80, 8'h00, 8'hFF, TYPE_INT8, 8'h7F,
           8'h7F, 8'hFF};
      send_message(m);
   endtask

   // An empty map finishes at once; the following byte is ignored.
   task automatic test_empty_map_and_trailing();
      byte_q_type m;
      m = header_bytes();
      m = {m, MAP_TAG, 8'h55};
      send_message(m);
   endtask

   task automatic test_framing_errors();
      byte_q_type m;
      m = {8'h00};
      send_message(m);
      m = {HDR_MARKER, 8'h52};
      send_message(m);
      m = header_bytes();
      m.push_back(8'h9F);
      send_message(m);
   endtask

   task automatic test_truncation();
      byte_q_type m;
      m = {HDR_MARKER};
      send_message(m);
      m = header_bytes();
      m = {m, 8'h82, 8'h01, 8'h05};
      send_message(m);
   endtask

   // With a limit of one the second pair overflows the table.
   task automatic test_table_full();
      byte_q_type m;
      set_pair_limit(4'd1);
      m = header_bytes();
      m = {m, 8'h82, 8'h01, 8'h02, 8'h03, 8'h04};
      send_message(m);
   endtask

   // Mostly well-formed maps, with truncated, corrupted, padded and noise messages mixed in.
   task automatic test_random_traffic(input logic [3:0] limit, input int byte_goal);
      byte_q_type m;
      int         tally;
      int         cut;
      int         pos;
      tally = 0;
      set_pair_limit(limit);
      while (tally < byte_goal) begin
         m = make_map($urandom_range(0, 15));
         case ($urandom_range(0, 9))
            7: begin
               cut = $urandom_range(1, m.size() - 1);
               while (m.size() > cut) void'(m.pop_back());
            end
            8: begin
               pos = $urandom_range(0, 1) ? $urandom_range(0, 5)
                                          : $urandom_range(0, m.size() - 1);
               m[pos] = 8'($urandom);
            end
            9: begin
               if ($urandom_range(0, 1)) begin
                  tally += m.size();
                  repeat ($urandom_range(1, 4)) m.push_back(8'($urandom));
                  tally -= m.size();
               end else begin
                  m.delete();
                  repeat ($urandom_range(1, 6)) m.push_back(8'($urandom));
               end
            end
            default: ;
         endcase
         tally += m.size();
         send_message(m);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      foreach (finish_codes[i]) finish_codes[i] = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_reset_value();
      test_well_formed_map();
      test_empty_map_and_trailing();
      test_framing_errors();
      test_truncation();
      test_table_full();
      test_random_traffic(4'd15, 350);
      test_random_traffic(4'd0, 150);
      test_random_traffic(4'($urandom_range(2, 14)), 350);
      test_random_traffic(4'd1, 150);
      test_random_traffic(4'($urandom_range(2, 14)), 400);
      wait_idle();

      $display("Run covered %0d bytes and %0d results, %0d of them with a pair.",
               bytes_accepted, reports_seen, pairs_seen_out);
      $display("Finish reports by code 0..5: %0d %0d %0d %0d %0d %0d", finish_codes[0],
               finish_codes[1], finish_codes[2], finish_codes[3], finish_codes[4],
               finish_codes[5]);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/tmmp_pkg.sv
sv/tmmp_req_if.sv
sv/tmmp_rsp_if.sv
sv/tmmp_csr.sv
sv/tmmp_in_stage.sv
sv/tmmp_parser.sv
sv/tagged_map_message_parser.sv
sv/tmmp_checker.sv
tb/tagged_map_message_parser_tb.sv
